[hdl/bfzb_pkg.sv]
package bfzb_pkg;

  localparam int ZONE_COUNT = 4;
  localparam int ALIGNMENT  = 16;
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 24;
  localparam int ASIZE_W    = SIZE_W + 1;
  localparam int STATUS_W   = 3;
  localparam int REG_COUNT  = 8;
  // one extra bit so that writes past the register list decode as misses
  localparam int CFG_IDX_W  = $clog2(REG_COUNT) + 1;
  localparam int ZONE_IDX_W = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int ZCNT_W     = $clog2(ZONE_COUNT + 1);

  localparam logic [ADDR_W:0]    ALIGN_MASK  = (ADDR_W + 1)'(ALIGNMENT - 1);
  localparam logic [ASIZE_W-1:0] ASIZE_MASK  = ASIZE_W'(ALIGNMENT - 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO_SIZE  = 3'd1,
    ST_NO_MEMORY  = 3'd2,
    ST_NO_HEAP    = 3'd3,
    ST_BAD_LAYOUT = 3'd4
  } status_e;

  typedef enum logic {
    CMD_INIT  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_CLR,
    S_INIT_STEP,
    S_INIT_END,
    S_CHECK,
    S_SCAN,
    S_PICK
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_CLR,
    OP_INIT_WRITE,
    OP_INIT_OK,
    OP_INIT_BAD,
    OP_REJECT,
    OP_SCAN,
    OP_ALLOC_DONE
  } op_e;

  typedef struct packed {
    logic slot_free;  // result register empty or draining this cycle
    logic zone_stop;  // current zone start is zero
    logic zone_bad;   // current zone rounds to start past end
    logic idx_last;   // current zone is the last one built in
    logic scan_done;  // all zones in use have been examined
    logic reject;     // zero size or no heap
  } dp_status_t;

endpackage

[hdl/bfzb_ctrl.sv]
module bfzb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   command_i,
  output logic                   in_ready_o,
  output bfzb_pkg::op_e          op_o,
  input  bfzb_pkg::dp_status_t   stat_i
);

  bfzb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfzb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = bfzb_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      bfzb_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o = bfzb_pkg::OP_LOAD;
          if (command_i == bfzb_pkg::CMD_INIT) begin
            state_d = bfzb_pkg::S_INIT_CLR;
          end else begin
            state_d = bfzb_pkg::S_CHECK;
          end
        end
      end
      bfzb_pkg::S_INIT_CLR: begin
        op_o    = bfzb_pkg::OP_INIT_CLR;
        state_d = bfzb_pkg::S_INIT_STEP;
      end
      bfzb_pkg::S_INIT_STEP: begin
        if (stat_i.zone_stop) begin
          if (stat_i.slot_free) begin
            op_o    = bfzb_pkg::OP_INIT_OK;
            state_d = bfzb_pkg::S_IDLE;
          end
        end else if (stat_i.zone_bad) begin
          if (stat_i.slot_free) begin
            op_o    = bfzb_pkg::OP_INIT_BAD;
            state_d = bfzb_pkg::S_IDLE;
          end
        end else begin
          op_o = bfzb_pkg::OP_INIT_WRITE;
          if (stat_i.idx_last) begin
            state_d = bfzb_pkg::S_INIT_END;
          end
        end
      end
      bfzb_pkg::S_INIT_END: begin
        if (stat_i.slot_free) begin
          op_o    = bfzb_pkg::OP_INIT_OK;
          state_d = bfzb_pkg::S_IDLE;
        end
      end
      bfzb_pkg::S_CHECK: begin
        if (stat_i.reject) begin
          if (stat_i.slot_free) begin
            op_o    = bfzb_pkg::OP_REJECT;
            state_d = bfzb_pkg::S_IDLE;
          end
        end else begin
          state_d = bfzb_pkg::S_SCAN;
        end
      end
      bfzb_pkg::S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = bfzb_pkg::S_PICK;
        end else begin
          op_o = bfzb_pkg::OP_SCAN;
        end
      end
      bfzb_pkg::S_PICK: begin
        if (stat_i.slot_free) begin
          op_o    = bfzb_pkg::OP_ALLOC_DONE;
          state_d = bfzb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bfzb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[hdl/bfzb_dp.sv]
module bfzb_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfzb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bfzb_pkg::ADDR_W-1:0]       cfg_data_i,
  input  logic [bfzb_pkg::SIZE_W-1:0]       request_size_i,
  input  bfzb_pkg::op_e                     op_i,
  output bfzb_pkg::dp_status_t              stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bfzb_pkg::STATUS_W-1:0]     status_o,
  output logic [bfzb_pkg::ADDR_W-1:0]       address_o
);

  localparam int ZC  = bfzb_pkg::ZONE_COUNT;
  localparam int AW  = bfzb_pkg::ADDR_W;
  localparam int ZIW = bfzb_pkg::ZONE_IDX_W;
  localparam int ZCW = bfzb_pkg::ZCNT_W;
  localparam int ASW = bfzb_pkg::ASIZE_W;

  // configured bounds
  logic [AW-1:0] zone_start_q [ZC];
  logic [AW-1:0] zone_end_q   [ZC];

  // heap state
  logic [AW-1:0] cursor_q [ZC];
  logic [AW-1:0] limit_q  [ZC];
  logic [ZCW-1:0] count_q;
  logic           heap_q;

  // per-item work registers
  logic [ZCW-1:0] idx_q;
  logic           size_zero_q;
  logic [ASW-1:0] asize_q;
  logic           best_valid_q;
  logic [ZIW-1:0] best_idx_q;
  logic [AW-1:0]  best_avail_q;

  // result register
  logic                      out_valid_q;
  bfzb_pkg::status_e         out_status_q;
  logic [AW-1:0]             out_addr_q;

  logic [ZIW-1:0] zi;
  logic [AW-1:0]  start_rd;
  logic [AW-1:0]  end_rd;
  logic [AW:0]    cur_rnd;
  logic [AW-1:0]  lim_rnd;
  logic [AW-1:0]  avail;
  logic           better;
  logic [ASW-1:0] req_asize;
  logic           result_load;

  assign zi       = idx_q[ZIW-1:0];
  assign start_rd = zone_start_q[zi];
  assign end_rd   = zone_end_q[zi];
  // round start up without wrapping, so a start near the top overflows into bit AW
  assign cur_rnd  = ({1'b0, start_rd} + bfzb_pkg::ALIGN_MASK) & ~bfzb_pkg::ALIGN_MASK;
  assign lim_rnd  = end_rd & ~bfzb_pkg::ALIGN_MASK[AW-1:0];
  assign avail    = limit_q[zi] - cursor_q[zi];
  assign better   = (AW'(asize_q) <= avail) && (!best_valid_q || (avail < best_avail_q));
  assign req_asize = ({1'b0, request_size_i} + bfzb_pkg::ASIZE_MASK) & ~bfzb_pkg::ASIZE_MASK;

  assign result_load = (op_i == bfzb_pkg::OP_INIT_OK) || (op_i == bfzb_pkg::OP_INIT_BAD) ||
                       (op_i == bfzb_pkg::OP_REJECT)  || (op_i == bfzb_pkg::OP_ALLOC_DONE);

  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign stat_o.zone_stop = (start_rd == '0);
  assign stat_o.zone_bad  = (cur_rnd > {1'b0, lim_rnd});
  assign stat_o.idx_last  = (idx_q == ZCW'(ZC - 1));
  assign stat_o.scan_done = (idx_q == count_q);
  assign stat_o.reject    = size_zero_q || !heap_q;

  // configuration writes; indices past the list fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ZC; k++) begin
        zone_start_q[k] <= '0;
        zone_end_q[k]   <= '0;
      end
    end else if (cfg_we_i) begin
      for (int k = 0; k < ZC; k++) begin
        if (cfg_idx_i == bfzb_pkg::CFG_IDX_W'(2 * k)) begin
          zone_start_q[k] <= cfg_data_i;
        end
        if (cfg_idx_i == bfzb_pkg::CFG_IDX_W'(2 * k + 1)) begin
          zone_end_q[k] <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ZC; k++) begin
        cursor_q[k] <= '0;
        limit_q[k]  <= '0;
      end
      count_q <= '0;
      heap_q  <= 1'b0;
    end else begin
      case (op_i) inside
        bfzb_pkg::OP_INIT_CLR, bfzb_pkg::OP_INIT_BAD: begin
          for (int k = 0; k < ZC; k++) begin
            cursor_q[k] <= '0;
            limit_q[k]  <= '0;
          end
          count_q <= '0;
          heap_q  <= 1'b0;
        end
        bfzb_pkg::OP_INIT_WRITE: begin
          cursor_q[zi] <= cur_rnd[AW-1:0];
          limit_q[zi]  <= lim_rnd;
        end
        bfzb_pkg::OP_INIT_OK: begin
          count_q <= idx_q;
          heap_q  <= 1'b1;
        end
        bfzb_pkg::OP_ALLOC_DONE: begin
          if (best_valid_q) begin
            cursor_q[best_idx_q] <= cursor_q[best_idx_q] + AW'(asize_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      size_zero_q  <= 1'b0;
      best_valid_q <= 1'b0;
    end else begin
      case (op_i)
        bfzb_pkg::OP_LOAD: begin
          idx_q        <= '0;
          size_zero_q  <= (request_size_i == '0);
          best_valid_q <= 1'b0;
        end
        bfzb_pkg::OP_INIT_WRITE: begin
          idx_q <= idx_q + 1'b1;
        end
        bfzb_pkg::OP_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (better) begin
            best_valid_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload of the scan: no reset needed
  always_ff @(posedge clk_i) begin
    if (op_i == bfzb_pkg::OP_LOAD) begin
      asize_q <= req_asize;
    end
    if ((op_i == bfzb_pkg::OP_SCAN) && better) begin
      best_idx_q   <= zi;
      best_avail_q <= avail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ready_i) || result_load;
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      bfzb_pkg::OP_INIT_OK: begin
        out_status_q <= bfzb_pkg::ST_OK;
        out_addr_q   <= '0;
      end
      bfzb_pkg::OP_INIT_BAD: begin
        out_status_q <= bfzb_pkg::ST_BAD_LAYOUT;
        out_addr_q   <= '0;
      end
      bfzb_pkg::OP_REJECT: begin
        out_status_q <= size_zero_q ? bfzb_pkg::ST_ZERO_SIZE : bfzb_pkg::ST_NO_HEAP;
        out_addr_q   <= '0;
      end
      bfzb_pkg::OP_ALLOC_DONE: begin
        if (best_valid_q) begin
          out_status_q <= bfzb_pkg::ST_OK;
          out_addr_q   <= cursor_q[best_idx_q];
        end else begin
          out_status_q <= bfzb_pkg::ST_NO_MEMORY;
          out_addr_q   <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign address_o   = out_addr_q;

endmodule

[hdl/best_fit_zone_bump_allocator_top.sv]
// Channel   Handshake                   Payload
// in        in_valid_i / in_ready_o     command_i, request_size_i
// out       out_valid_o / out_ready_i   status_o, address_o
// cfg       cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
//
// Initialize: a clearing step, then a walk over the zones in the list, which
// visits one configured start/end pair per cycle.
// Allocate: a check step, then the best-fit scan over the zones in use, reading one
// cursor/limit pair per cycle, then a pick. Check rejects zero size and no heap.
// Reset clears the heap state and all zone registers; no clearing pass.
// A result held in the output register stalls only the final step of the next item.
module best_fit_zone_bump_allocator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfzb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bfzb_pkg::ADDR_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [bfzb_pkg::SIZE_W-1:0]       request_size_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bfzb_pkg::STATUS_W-1:0]     status_o,
  output logic [bfzb_pkg::ADDR_W-1:0]       address_o
);

  bfzb_pkg::op_e        op;
  bfzb_pkg::dp_status_t stat;

  bfzb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_ready_o (in_ready_o),
    .op_o       (op),
    .stat_i     (stat)
  );

  bfzb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .request_size_i (request_size_i),
    .op_i           (op),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .address_o      (address_o)
  );

endmodule
